[design/flash_erase_before_write_tracker_unit_defines.svh]
// assertion helpers shared by the tracker modules
`ifndef FLASH_ERASE_BEFORE_WRITE_TRACKER_UNIT_DEFINES_SVH
`define FLASH_ERASE_BEFORE_WRITE_TRACKER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FBW_ASSERT_SAME(name, clock, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FBW_ASSERT_NEXT(name, clock, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/fbw_pkg.sv]
package fbw_pkg;

	// field widths
	localparam int ADDR_W     = 24;
	localparam int LEN_W      = 13;
	localparam int LG_W       = 5;
	localparam int CNT_W      = 9;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// stream packing
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - LEN_W;

	// mark memory organization: rows of eight marks
	localparam int BLK_W    = 8;
	localparam int COL_W    = 3;
	localparam int ROW_W    = BLK_W - COL_W;
	localparam int NUM_ROWS = 1 << ROW_W;
	localparam int ROW_BITS = 1 << COL_W;

	// limits
	localparam logic [LG_W-1:0]  LOG2_MIN        = 5'd9;
	localparam logic [LG_W-1:0]  LOG2_MAX        = 5'd20;
	localparam logic [CNT_W-1:0] MAX_BLOCKS      = 9'd256;
	localparam logic [LEN_W-1:0] MAX_WRITE_BYTES = 13'd4096;
	localparam int               MAX_SPAN        = 9;

	// register reset values
	localparam logic [LG_W-1:0]  LG_RESET     = 5'd12;
	localparam logic [CNT_W-1:0] BLOCKS_RESET = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE_LOG2 = 1'b0,
		REG_BLOCKS_IN_USE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ERASE  = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_REJECT = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] target_address;
		logic [LEN_W-1:0]  write_length;
		logic              last;
	} res_t;

	typedef struct packed {
		logic             reject;
		logic [BLK_W-1:0] first_blk;
		logic [BLK_W-1:0] last_blk;
		logic [LG_W-1:0]  lg;
	} chk_t;

	typedef struct packed {
		logic                rd_en;
		logic [ROW_W-1:0]    rd_row;
		logic                wr_en;
		logic [ROW_W-1:0]    wr_row;
		logic [ROW_BITS-1:0] wr_data;
		logic                clear;
	} mark_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_FETCH,
		ST_WALK,
		ST_FINISH
	} walk_state_t;

endpackage

[design/fbw_mark_store.sv]
`include "flash_erase_before_write_tracker_unit_defines.svh"

module fbw_mark_store
	import fbw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mark_req_t           req,
	output logic [ROW_BITS-1:0] rd_data
);

	logic [ROW_BITS-1:0] mem [NUM_ROWS];
	logic [NUM_ROWS-1:0] row_valid_q;
	logic [ROW_BITS-1:0] mem_s1;
	logic                valid_s1;

	// row memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_row] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_s1 <= mem[req.rd_row];
		end
	end

	// per-row written flags, dropped at once by reset or a clear request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (req.clear) begin
				row_valid_q <= '0;
			end else if (req.wr_en) begin
				row_valid_q[req.wr_row] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_s1 <= row_valid_q[req.rd_row];
			end
		end
	end

	// a row never written since the last clear reads as all clear
	assign rd_data = valid_s1 ? mem_s1 : '0;

	`FBW_ASSERT_SAME(a_clear_without_write, clk, arst_n, req.clear, !req.wr_en && !req.rd_en, "mark clear overlaps a memory access")

endmodule

[design/fbw_req_check.sv]
module fbw_req_check
	import fbw_pkg::*;
(
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  length,
	input  logic [LG_W-1:0]   block_size_log2,
	input  logic [CNT_W-1:0]  blocks_in_use,
	output chk_t              chk
);

	logic [LG_W-1:0]  lg;
	logic [CNT_W-1:0] count;
	logic [ADDR_W:0]  end_addr;
	logic [ADDR_W:0]  first_full;
	logic [ADDR_W:0]  last_full;
	logic [ADDR_W:0]  span;

	// clamp settings, find the touched block range and check its limits
	always_comb begin
		lg = block_size_log2;
		if (lg < LOG2_MIN) begin
			lg = LOG2_MIN;
		end else if (lg > LOG2_MAX) begin
			lg = LOG2_MAX;
		end
		count = (blocks_in_use > MAX_BLOCKS) ? MAX_BLOCKS : blocks_in_use;

		end_addr   = {1'b0, address} + (ADDR_W + 1)'(length) - (ADDR_W + 1)'(1);
		first_full = {1'b0, address} >> lg;
		last_full  = end_addr >> lg;
		span       = last_full - first_full + (ADDR_W + 1)'(1);

		chk.reject    = (length == '0) || (length > MAX_WRITE_BYTES) || end_addr[ADDR_W] ||
		                (last_full >= (ADDR_W + 1)'(count)) ||
		                (span > (ADDR_W + 1)'(MAX_SPAN));
		chk.first_blk = first_full[BLK_W-1:0];
		chk.last_blk  = last_full[BLK_W-1:0];
		chk.lg        = lg;
	end

endmodule

[design/fbw_walker.sv]
`include "flash_erase_before_write_tracker_unit_defines.svh"

module fbw_walker
	import fbw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                func,
	input  logic [ADDR_W-1:0]   address,
	input  logic [LEN_W-1:0]    length,
	input  logic [LG_W-1:0]     cfg_lg,
	input  logic [CNT_W-1:0]    cfg_blocks,
	output mark_req_t           mem_req,
	input  logic [ROW_BITS-1:0] rd_data,
	input  logic                out_free,
	output logic                push,
	output res_t                res
);

	walk_state_t         state_q, state_d;
	logic [ADDR_W-1:0]   addr_q;
	logic [LEN_W-1:0]    len_q;
	logic [BLK_W-1:0]    blk_q;
	logic [BLK_W-1:0]    last_q;
	logic [LG_W-1:0]     blk_lg_q;
	logic                reject_q;
	logic [ROW_BITS-1:0] row_buf_q;
	chk_t                chk;
	logic [COL_W-1:0]    col;
	logic [ROW_BITS-1:0] col_bit;
	logic [ADDR_W+BLK_W-1:0] wide_addr;
	logic                advance;
	logic                set_bit;

	fbw_req_check u_check (
		.address         (addr_q),
		.length          (len_q),
		.block_size_log2 (cfg_lg),
		.blocks_in_use   (cfg_blocks),
		.chk             (chk)
	);

	// position of the current block inside the buffered row
	assign col       = blk_q[COL_W-1:0];
	assign col_bit   = ROW_BITS'(1) << col;
	assign wide_addr = (ADDR_W + BLK_W)'(blk_q) << blk_lg_q;

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mem_req  = '0;
		push     = 1'b0;
		res      = '0;
		advance  = 1'b0;
		set_bit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (func) begin
						mem_req.clear = 1'b1;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				state_d = chk.reject ? ST_FINISH : ST_LOAD;
			end
			ST_LOAD: begin
				mem_req.rd_en  = 1'b1;
				mem_req.rd_row = blk_q[BLK_W-1:COL_W];
				state_d        = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!row_buf_q[col]) begin
					if (out_free) begin
						push               = 1'b1;
						res.command        = CMD_ERASE;
						res.target_address = wide_addr[ADDR_W-1:0];
						set_bit            = 1'b1;
						mem_req.wr_en      = 1'b1;
						mem_req.wr_row     = blk_q[BLK_W-1:COL_W];
						mem_req.wr_data    = row_buf_q | col_bit;
						advance            = 1'b1;
					end
				end else begin
					advance = 1'b1;
				end
				if (advance) begin
					if (blk_q == last_q) begin
						state_d = ST_FINISH;
					end else if (col == '1) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push = 1'b1;
					if (reject_q) begin
						res.command = CMD_REJECT;
					end else begin
						res.command        = CMD_WRITE;
						res.target_address = addr_q;
						res.write_length   = len_q;
					end
					res.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request, range and row buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && !func) begin
			addr_q <= address;
			len_q  <= length;
		end
		if (state_q == ST_CHECK) begin
			blk_q    <= chk.first_blk;
			last_q   <= chk.last_blk;
			blk_lg_q <= chk.lg;
			reject_q <= chk.reject;
		end
		if (state_q == ST_FETCH) begin
			row_buf_q <= rd_data;
		end
		if (set_bit) begin
			row_buf_q <= row_buf_q | col_bit;
		end
		if (advance) begin
			blk_q <= blk_q + BLK_W'(1);
		end
	end

	`FBW_ASSERT_NEXT(a_last_to_idle, clk, arst_n, push && res.last, state_q == ST_IDLE, "walker did not return to idle after the last transfer")
	`FBW_ASSERT_SAME(a_walk_in_range, clk, arst_n, state_q == ST_WALK, blk_q <= last_q, "walk passed the last block of the request")
	`FBW_ASSERT_SAME(a_erase_sets_mark, clk, arst_n, push && res.command == CMD_ERASE, mem_req.wr_en && mem_req.wr_row == blk_q[BLK_W-1:COL_W], "erase issued without updating its mark row")

endmodule

[design/fbw_out_slot.sv]
module fbw_out_slot
	import fbw_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  res_t                   res_in,
	output logic                   out_free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // target_address, write_length, zero pad
	output logic [CMD_W-1:0]       m_tuser,   // command
	output logic                   m_tlast
);

	logic valid_q;
	res_t res_q;

	// slot can take a new result when empty or being drained this cycle
	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_in;
		end
	end

	// result transfer
	assign m_tvalid = valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_q.write_length, res_q.target_address};
	assign m_tuser  = res_q.command;
	assign m_tlast  = res_q.last;

endmodule

[design/flash_erase_before_write_tracker_unit.sv]
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tdata: address[23:0], length[36:24]; tuser: func
// m_       out  m_tvalid/m_tready  tdata: target_address[23:0], write_length[36:24];
//                                  tuser: command; tlast: last
// cfg_     in   cfg_wr_en          cfg_index selects register, cfg_data value
//
// a clear request is handled in idle and stays there; a rejected write goes from
// check straight to finish; a write goes through check, then for each row of eight
// marks it touches a load and a fetch for the registered row read and a walk over
// that row's blocks, and ends in finish, which gives the write result
// reset and clear drop all marks at once through per-row flags, no clearing pass
// one result per cycle at most; a stalled m_ side holds the walk, the input takes
// the next request while the final result still waits in the output register
module flash_erase_before_write_tracker_unit
	import fbw_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // address, length, zero pad
	input  logic                   s_tuser,   // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // target_address, write_length, zero pad
	output logic [CMD_W-1:0]       m_tuser,   // command
	output logic                   m_tlast,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [LG_W-1:0]     lg_cfg_q;
	logic [CNT_W-1:0]    blocks_cfg_q;
	mark_req_t           mem_req;
	logic [ROW_BITS-1:0] rd_data;
	logic                out_free;
	logic                push;
	res_t                res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_cfg_q     <= LG_RESET;
			blocks_cfg_q <= BLOCKS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BLOCK_SIZE_LOG2: lg_cfg_q     <= cfg_data[LG_W-1:0];
				REG_BLOCKS_IN_USE:   blocks_cfg_q <= cfg_data[CNT_W-1:0];
				default:             lg_cfg_q     <= lg_cfg_q;
			endcase
		end
	end

	fbw_mark_store u_marks (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	fbw_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.func       (s_tuser),
		.address    (s_tdata[ADDR_W-1:0]),
		.length     (s_tdata[ADDR_W+LEN_W-1:ADDR_W]),
		.cfg_lg     (lg_cfg_q),
		.cfg_blocks (blocks_cfg_q),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.out_free   (out_free),
		.push       (push),
		.res        (res)
	);

	fbw_out_slot u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res_in   (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[tb/tb_flash_erase_before_write_tracker_unit.sv]
module tb_flash_erase_before_write_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fbw_pkg::*;

	localparam int NUM_BLOCKS = 256;
	localparam int SETTLE_CYCLES = 20;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // address, length, zero pad
	logic                   s_tuser = 1'b0;  // func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // target_address, write_length, zero pad
	logic [CMD_W-1:0]       m_tuser;         // command
	logic                   m_tlast;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// shadow copy of the tracker state
	bit [NUM_BLOCKS-1:0] erased_blk = '0;
	logic [LG_W-1:0]     cur_log2 = LG_RESET;
	logic [CNT_W-1:0]    cur_blocks = BLOCKS_RESET;
	res_t                pending_cmds[$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int errors = 0;
	int n_sent = 0;
	int n_cfg = 0;
	int n_erase = 0;
	int n_write = 0;
	int n_reject = 0;

	flash_erase_before_write_tracker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// random back-pressure on the command output
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// block size and count as the hardware clamps them
	function automatic int unsigned eff_log2();
		if (cur_log2 < LOG2_MIN)
			return 32'(LOG2_MIN);
		if (cur_log2 > LOG2_MAX)
			return 32'(LOG2_MAX);
		return 32'(cur_log2);
	endfunction

	function automatic int unsigned eff_count();
		if (cur_blocks > MAX_BLOCKS)
			return 32'(MAX_BLOCKS);
		return 32'(cur_blocks);
	endfunction

	// work out the commands one request produces and update the marks
	task automatic track_request(logic func, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
		int unsigned lg;
		int unsigned cnt;
		int unsigned end_addr;
		int unsigned first_b;
		int unsigned last_b;
		res_t r;
		if (func) begin
			erased_blk = '0;
			return;
		end
		lg = eff_log2();
		cnt = eff_count();
		r.command = CMD_REJECT;
		r.target_address = '0;
		r.write_length = '0;
		r.last = 1'b1;
		if (len == '0 || len > MAX_WRITE_BYTES) begin
			pending_cmds.push_back(r);
			return;
		end
		end_addr = 32'(addr) + 32'(len) - 32'd1;
		first_b = 32'(addr) >> lg;
		last_b = end_addr >> lg;
		if (end_addr > 32'hFF_FFFF || last_b >= cnt || last_b - first_b + 1 > MAX_SPAN) begin
			pending_cmds.push_back(r);
			return;
		end
		// walk upward, erasing every block not yet marked
		for (int unsigned b = first_b; b <= last_b; b++) begin
			if (!erased_blk[b[BLK_W-1:0]]) begin
				r.command = CMD_ERASE;
				r.target_address = ADDR_W'(b << lg);
				r.write_length = '0;
				r.last = 1'b0;
				pending_cmds.push_back(r);
				erased_blk[b[BLK_W-1:0]] = 1'b1;
			end
		end
		r.command = CMD_WRITE;
		r.target_address = addr;
		r.write_length = len;
		r.last = 1'b1;
		pending_cmds.push_back(r);
	endtask

	// one request transfer, with random gaps before it
	task automatic send_request(logic func, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {{(IN_TDATA_W - ADDR_W - LEN_W){1'b0}}, len, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_request(func, addr, len);
		n_sent++;
	endtask

	// drain all commands, then allow for a trailing clear to finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_BLOCK_SIZE_LOG2: cur_log2 = val[LG_W-1:0];
			REG_BLOCKS_IN_USE:   cur_blocks = val;
			default: ;
		endcase
		n_cfg++;
	endtask

	// compare every command transfer with the oldest prediction
	always @(posedge clk) begin : cmd_check
		res_t got;
		res_t exp_cmd;
		if (arst_n && m_tvalid && m_tready) begin
			got.command = cmd_t'(m_tuser);
			got.target_address = m_tdata[ADDR_W-1:0];
			got.write_length = m_tdata[ADDR_W +: LEN_W];
			got.last = m_tlast;
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command cmd=%0d addr=%h len=%0d last=%b", $realtime,
					m_tuser, got.target_address, got.write_length, got.last);
				errors++;
			end else begin
				exp_cmd = pending_cmds.pop_front();
				if (got !== exp_cmd) begin
					$display("%0t: mismatch expected cmd=%0d addr=%h len=%0d last=%b", $realtime,
						exp_cmd.command, exp_cmd.target_address, exp_cmd.write_length,
						exp_cmd.last);
					$display("%0t:          actual   cmd=%0d addr=%h len=%0d last=%b", $realtime,
						m_tuser, got.target_address, got.write_length, got.last);
					errors++;
				end
				case (exp_cmd.command)
					CMD_ERASE: n_erase++;
					CMD_WRITE: n_write++;
					default:   n_reject++;
				endcase
			end
		end
	end

	// erase marks with reset geometry: first touch, reuse, clear, re-erase
	task automatic test_mark_tracking();
		send_request(1'b0, 24'h000000, 13'd1);
		send_request(1'b0, 24'h000FFF, 13'd2);
		send_request(1'b0, 24'h000010, 13'd4096);
		send_request(1'b1, 24'h000000, 13'd0);
		send_request(1'b0, 24'h000800, 13'd4096);
		send_request(1'b0, 24'h0FFFFF, 13'd1);
	endtask

	// zero and oversize lengths, past the block count, then a clear with noisy fields
	task automatic test_rejections();
		send_request(1'b0, 24'h123456, 13'd0);
		send_request(1'b0, 24'h000000, 13'd4097);
		send_request(1'b0, 24'hAAAAAA, 13'd8191);
		send_request(1'b0, 24'h100000, 13'd1);
		send_request(1'b0, 24'hFFFFFF, 13'd1);
		send_request(1'b1, 24'h555555, 13'h1555);
	endtask

	// smallest and largest block sizes, clamped values, no usable blocks
	task automatic test_register_extremes();
		write_reg(REG_BLOCK_SIZE_LOG2, 9'd9);
		write_reg(REG_BLOCKS_IN_USE, 9'd511);
		send_request(1'b0, 24'h0001FF, 13'd4096);
		send_request(1'b0, 24'h01FFFF, 13'd1);
		write_reg(REG_BLOCK_SIZE_LOG2, 9'd20);
		write_reg(REG_BLOCKS_IN_USE, 9'd16);
		send_request(1'b0, 24'hFFFFFF, 13'd1);
		send_request(1'b0, 24'hFFF000, 13'd4096);
		send_request(1'b0, 24'hFFF001, 13'd4096);
		write_reg(REG_BLOCK_SIZE_LOG2, 9'd0);
		write_reg(REG_BLOCKS_IN_USE, 9'd0);
		send_request(1'b0, 24'h000000, 13'd1);
		write_reg(REG_BLOCK_SIZE_LOG2, 9'd31);
		write_reg(REG_BLOCKS_IN_USE, 9'd1);
		send_request(1'b0, 24'h0FFFFF, 13'd1);
		send_request(1'b0, 24'h100000, 13'd1);
	endtask

	// mostly in-range writes over random geometry, plus clears, rejects and noise
	task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
		int unsigned lg;
		int unsigned cnt;
		int unsigned max_blk;
		int unsigned blk;
		int unsigned pick;
		logic [31:0] a;
		logic [LEN_W-1:0] len;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		for (int seg = 0; seg < 3; seg++) begin
			write_reg(REG_BLOCK_SIZE_LOG2, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 31) : $urandom_range(9, 20)));
			case ($urandom_range(0, 3))
				0:       write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(1, 8)));
				1:       write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(1, 64)));
				2:       write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(1, 256)));
				default: write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(257, 511)));
			endcase
			lg = eff_log2();
			cnt = eff_count();
			max_blk = ((cnt < (1 << (24 - lg))) ? cnt : (1 << (24 - lg))) - 1;
			for (int i = 0; i < n_items / 3; i++) begin
				pick = $urandom_range(0, 99);
				blk = ($urandom_range(0, 7) == 0) ? max_blk : $urandom_range(0, max_blk);
				a = (blk << lg) | ($urandom & ((1 << lg) - 1));
				case ($urandom_range(0, 3))
					0, 1:    len = LEN_W'($urandom_range(1, 512));
					2:       len = LEN_W'($urandom_range(1, 4096));
					default: len = LEN_W'(4096 - $urandom_range(0, 3));
				endcase
				if (pick < 8)
					send_request(1'b1, ADDR_W'($urandom), LEN_W'($urandom));
				else if (pick < 14)
					send_request(1'b0, ADDR_W'($urandom), LEN_W'($urandom));
				else if (pick < 18)
					send_request(1'b0, a[ADDR_W-1:0], $urandom_range(0, 1) ?
						13'd0 : LEN_W'($urandom_range(4097, 8191)));
				else
					send_request(1'b0, a[ADDR_W-1:0], len);
			end
		end
	endtask

	initial begin
		src_idle_pct = 27;
		sink_idle_pct = 79;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mark_tracking();
		test_rejections();
		test_register_extremes();
		test_random_traffic(27, 79, 135);
		test_random_traffic(79, 27, 135);
		test_random_traffic(0, 0, 135);
		wait_idle();
		$display("sent %0d requests with %0d register writes", n_sent, n_cfg);
		$display("checked %0d erase, %0d write, %0d reject; idle mixes 27/79, 79/27, none",
			n_erase, n_write, n_reject);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d commands outstanding", $realtime, pending_cmds.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
